@@ rtl/cslt_pkg.sv @@
// Package for the credit slot lifecycle tracker: widths, slot count, codes and
// the structs passed between the top level and the slot lanes. No dependencies.
`default_nettype none

package cslt_pkg;

  localparam int SLOTS = 2;   // 1 to 16
  localparam int IDX_W = 4;
  localparam int GEN_W = 64;
  localparam int ID_W  = 64;
  localparam int OP_W  = 3;

  typedef enum logic [2:0] {
    ST_FREE      = 3'd0,
    ST_PREPARED  = 3'd1,
    ST_COMMITTED = 3'd2,
    ST_VERIFIED  = 3'd3,
    ST_SUSPECT   = 3'd4
  } slot_state_t;

  typedef enum logic [2:0] {
    OP_RESERVE  = 3'd0,
    OP_ABORT    = 3'd1,
    OP_COMMIT   = 3'd2,
    OP_COMPLETE = 3'd3,
    OP_RELEASE  = 3'd4,
    OP_SUSPECT  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_INVALID   = 2'd1,
    RC_PRECOND   = 2'd2,
    RC_EXHAUSTED = 2'd3
  } status_t;

  // Update request from the top level to one slot lane
  typedef struct packed {
    logic        take;        // reserve: bump generation, store ids, go prepared
    logic        drop;        // abort or release: free, clear ids
    logic        move;        // plain state change
    slot_state_t next_state;
  } slot_cmd_t;

  // Per-slot comparison results against the item in flight
  typedef struct packed {
    logic        is_free;
    logic        dup;         // busy slot already holds this plan and ordinal
    logic        id_match;    // generation, plan and ordinal all match the handle
    logic        gen_max;     // generation is all ones
    slot_state_t state;
  } slot_stat_t;

endpackage

`default_nettype wire

@@ rtl/cslt_slot.sv @@
// One credit slot: lifecycle state, generation, plan and ordinal registers,
// plus the comparators against the item in flight. Depends on cslt_pkg.
`default_nettype none

module cslt_slot (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [cslt_pkg::GEN_W-1:0] hnd_gen,
  input  wire logic [cslt_pkg::ID_W-1:0]  plan,
  input  wire logic [cslt_pkg::ID_W-1:0]  ord,
  input  wire cslt_pkg::slot_cmd_t      cmd,
  output cslt_pkg::slot_stat_t          stat,
  output logic [cslt_pkg::GEN_W-1:0]    generation
);

  cslt_pkg::slot_state_t        state_r, state_nxt;
  logic [cslt_pkg::GEN_W-1:0]   gen_r, gen_nxt;
  logic [cslt_pkg::ID_W-1:0]    plan_r, plan_nxt;
  logic [cslt_pkg::ID_W-1:0]    ord_r, ord_nxt;
  logic                         ids_eq;

  assign ids_eq = (plan_r == plan) && (ord_r == ord);

  always_comb begin
    stat.is_free  = (state_r == cslt_pkg::ST_FREE);
    stat.dup      = (state_r != cslt_pkg::ST_FREE) && ids_eq;
    stat.id_match = (gen_r == hnd_gen) && ids_eq;
    stat.gen_max  = &gen_r;
    stat.state    = state_r;
  end

  assign generation = gen_r;

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    plan_nxt  = plan_r;
    ord_nxt   = ord_r;
    if (cmd.take) begin
      state_nxt = cslt_pkg::ST_PREPARED;
      gen_nxt   = gen_r + cslt_pkg::GEN_W'(1);
      plan_nxt  = plan;
      ord_nxt   = ord;
    end else if (cmd.drop) begin
      state_nxt = cslt_pkg::ST_FREE;
      plan_nxt  = '0;
      ord_nxt   = '0;
    end else if (cmd.move) begin
      state_nxt = cmd.next_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cslt_pkg::ST_FREE;
      gen_r   <= '0;
      plan_r  <= '0;
      ord_r   <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      plan_r  <= plan_nxt;
      ord_r   <= ord_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/credit_slot_lifecycle_tracker.sv @@
// Credit slot lifecycle tracker, top level. Uses cslt_pkg and cslt_slot.
// Pipeline: input register, then result register; out_valid rises when the item
// moves into the result register. Throughput: one item per cycle unless out_stall
// holds a result; the slot lanes are compared in parallel and updated at the edge
// the item moves into the result register.
// Reset (rst_n low, synchronous): all slots free with zero generation and ids,
// poisoned flag clear, both pipeline registers empty.
`default_nettype none

module credit_slot_lifecycle_tracker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [cslt_pkg::OP_W-1:0]  in_opcode,
  input  wire logic [cslt_pkg::IDX_W-1:0] in_slot_index,
  input  wire logic [cslt_pkg::GEN_W-1:0] in_handle_generation,
  input  wire logic [cslt_pkg::ID_W-1:0]  in_plan_sequence,
  input  wire logic [cslt_pkg::ID_W-1:0]  in_op_ordinal,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_status,
  output logic [cslt_pkg::IDX_W-1:0]      out_granted_index,
  output logic [cslt_pkg::GEN_W-1:0]      out_granted_generation,
  output logic                            out_poisoned_flag
);

  localparam int SLOTS = cslt_pkg::SLOTS;

  // input register
  logic                        s1_valid_r;
  logic [cslt_pkg::OP_W-1:0]   s1_op_r;
  logic [cslt_pkg::IDX_W-1:0]  s1_idx_r;
  logic [cslt_pkg::GEN_W-1:0]  s1_gen_r;
  logic [cslt_pkg::ID_W-1:0]   s1_plan_r;
  logic [cslt_pkg::ID_W-1:0]   s1_ord_r;

  // result register
  logic                        out_valid_r;
  cslt_pkg::status_t           out_status_r;
  logic [cslt_pkg::IDX_W-1:0]  out_idx_r;
  logic [cslt_pkg::GEN_W-1:0]  out_gen_r;
  logic                        out_poison_r;

  logic                        poisoned_r, poisoned_nxt;
  logic                        advance;

  cslt_pkg::slot_stat_t        stat [SLOTS];
  cslt_pkg::slot_cmd_t         cmd  [SLOTS];
  logic [cslt_pkg::GEN_W-1:0]  slot_gen [SLOTS];

  cslt_pkg::status_t           rc;
  logic                        poison_set;
  logic [SLOTS-1:0]            take_v;
  logic [SLOTS-1:0]            upd_v;
  logic                        is_drop;
  cslt_pkg::slot_state_t       want, next_state;
  logic [cslt_pkg::IDX_W-1:0]  grant_idx;
  logic [cslt_pkg::GEN_W-1:0]  grant_gen;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    cslt_slot u_slot (
      .clk        (clk),
      .rst_n      (rst_n),
      .hnd_gen    (s1_gen_r),
      .plan       (s1_plan_r),
      .ord        (s1_ord_r),
      .cmd        (cmd[g]),
      .stat       (stat[g]),
      .generation (slot_gen[g])
    );
  end

  always_comb begin
    logic                        dup_any;
    logic                        found;
    logic                        ff_full;
    logic [SLOTS-1:0]            ff;
    logic [SLOTS-1:0]            sel;
    logic                        hit;
    logic                        idx_ok;
    logic                        any_zero;
    logic [cslt_pkg::IDX_W-1:0]  ff_idx;
    logic [cslt_pkg::GEN_W-1:0]  ff_gen;

    dup_any    = 1'b0;
    found      = 1'b0;
    ff_full    = 1'b0;
    ff         = '0;
    sel        = '0;
    hit        = 1'b0;
    ff_idx     = '0;
    ff_gen     = '0;
    rc         = cslt_pkg::RC_INVALID;
    poison_set = 1'b0;
    take_v     = '0;
    upd_v      = '0;
    is_drop    = 1'b0;
    want       = cslt_pkg::ST_PREPARED;
    next_state = cslt_pkg::ST_FREE;
    grant_idx  = '0;
    grant_gen  = '0;

    idx_ok   = ({1'b0, s1_idx_r} < (cslt_pkg::IDX_W+1)'(SLOTS));
    any_zero = (s1_gen_r == '0) || (s1_plan_r == '0) || (s1_ord_r == '0);

    // lowest free slot, duplicate check and handle match, all lanes at once
    for (int k = 0; k < SLOTS; k++) begin
      dup_any = dup_any | stat[k].dup;
      if (stat[k].is_free && !found) begin
        found     = 1'b1;
        ff[k]     = 1'b1;
        ff_idx    = cslt_pkg::IDX_W'(k);
        ff_full   = stat[k].gen_max;
        ff_gen    = slot_gen[k];
      end
      sel[k] = (s1_idx_r == cslt_pkg::IDX_W'(k));
    end

    case (cslt_pkg::op_t'(s1_op_r))
      cslt_pkg::OP_ABORT: begin
        want = cslt_pkg::ST_PREPARED;   next_state = cslt_pkg::ST_FREE;     is_drop = 1'b1;
      end
      cslt_pkg::OP_COMMIT: begin
        want = cslt_pkg::ST_PREPARED;   next_state = cslt_pkg::ST_COMMITTED;
      end
      cslt_pkg::OP_COMPLETE: begin
        want = cslt_pkg::ST_COMMITTED;  next_state = cslt_pkg::ST_VERIFIED;
      end
      cslt_pkg::OP_RELEASE: begin
        want = cslt_pkg::ST_VERIFIED;   next_state = cslt_pkg::ST_FREE;     is_drop = 1'b1;
      end
      cslt_pkg::OP_SUSPECT: begin
        want = cslt_pkg::ST_COMMITTED;  next_state = cslt_pkg::ST_SUSPECT;
      end
      default: begin
        want = cslt_pkg::ST_PREPARED;   next_state = cslt_pkg::ST_FREE;
      end
    endcase

    for (int k = 0; k < SLOTS; k++) begin
      hit = hit | (sel[k] && stat[k].id_match && (stat[k].state == want));
    end

    case (cslt_pkg::op_t'(s1_op_r))
      cslt_pkg::OP_RESERVE: begin
        if (poisoned_r || (s1_plan_r == '0) || (s1_ord_r == '0) || dup_any) begin
          rc = cslt_pkg::RC_PRECOND;
        end else if (!found) begin
          rc = cslt_pkg::RC_EXHAUSTED;
        end else if (ff_full) begin
          // generation would wrap: slot untouched, block poisoned
          rc         = cslt_pkg::RC_EXHAUSTED;
          poison_set = 1'b1;
        end else begin
          rc        = cslt_pkg::RC_OK;
          take_v    = ff;
          grant_idx = ff_idx;
          grant_gen = ff_gen + cslt_pkg::GEN_W'(1);
        end
      end
      cslt_pkg::OP_ABORT, cslt_pkg::OP_COMMIT, cslt_pkg::OP_COMPLETE,
      cslt_pkg::OP_RELEASE, cslt_pkg::OP_SUSPECT: begin
        if (!idx_ok || any_zero) begin
          rc = cslt_pkg::RC_INVALID;
        end else if (!hit) begin
          rc = cslt_pkg::RC_PRECOND;
        end else begin
          rc         = cslt_pkg::RC_OK;
          upd_v      = sel;
          poison_set = (cslt_pkg::op_t'(s1_op_r) == cslt_pkg::OP_SUSPECT);
        end
      end
      default: begin
        rc = cslt_pkg::RC_INVALID;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      cmd[k].take       = advance && take_v[k];
      cmd[k].drop       = advance && upd_v[k] && is_drop;
      cmd[k].move       = advance && upd_v[k] && !is_drop;
      cmd[k].next_state = next_state;
    end
  end

  assign poisoned_nxt = poisoned_r || (advance && poison_set);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      poisoned_r  <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      poisoned_r <= poisoned_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op_r   <= in_opcode;
      s1_idx_r  <= in_slot_index;
      s1_gen_r  <= in_handle_generation;
      s1_plan_r <= in_plan_sequence;
      s1_ord_r  <= in_op_ordinal;
    end
    if (advance) begin
      out_status_r <= rc;
      out_idx_r    <= grant_idx;
      out_gen_r    <= grant_gen;
      out_poison_r <= poisoned_r || poison_set;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_granted_index      = out_idx_r;
  assign out_granted_generation = out_gen_r;
  assign out_poisoned_flag      = out_poison_r;

  // poisoned is sticky
  a_poison_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    poisoned_r |=> poisoned_r)
    else $error("poisoned flag cleared");

  // at most one slot taken per reserve
  a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(take_v))
    else $error("more than one slot reserved");

  // a nonzero granted generation only comes with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_gen_r != '0)) |-> (out_status_r == cslt_pkg::RC_OK))
    else $error("grant without ok status");

  // the input side only stalls on a held item
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("stall without backpressure");

endmodule

`default_nettype wire

@@ tb/credit_slot_lifecycle_tracker_tb.sv @@
// Self-checking testbench for credit_slot_lifecycle_tracker: directed and random
// slot lifecycles against an in-bench slot model. Depends on cslt_pkg and the RTL.
`default_nettype none

module credit_slot_lifecycle_tracker_tb;
  import cslt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic [GEN_W-1:0] generation;
    logic             poisoned;
  } grant_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  in_opcode = '0;
  logic [IDX_W-1:0] in_slot_index = '0;
  logic [GEN_W-1:0] in_handle_generation = '0;
  logic [ID_W-1:0]  in_plan_sequence = '0;
  logic [ID_W-1:0]  in_op_ordinal = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_granted_index;
  logic [GEN_W-1:0] out_granted_generation;
  logic             out_poisoned_flag;

  // slot model
  slot_state_t      lane_state [SLOTS];
  logic [GEN_W-1:0] lane_gen [SLOTS];
  logic [ID_W-1:0]  lane_plan [SLOTS];
  logic [ID_W-1:0]  lane_ord [SLOTS];
  logic             is_poisoned;

  grant_result_t    expected_grants[$];
  int               errors = 0;
  int               cycles = 0;
  int               burst_left = 0;
  int               stall_mode = 0;
  int               mode_left = 0;

  credit_slot_lifecycle_tracker dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_opcode              (in_opcode),
    .in_slot_index          (in_slot_index),
    .in_handle_generation   (in_handle_generation),
    .in_plan_sequence       (in_plan_sequence),
    .in_op_ordinal          (in_op_ordinal),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_granted_index      (out_granted_index),
    .out_granted_generation (out_granted_generation),
    .out_poisoned_flag      (out_poisoned_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      lane_state[k] = ST_FREE;
      lane_gen[k]   = '0;
      lane_plan[k]  = '0;
      lane_ord[k]   = '0;
    end
    is_poisoned = 1'b0;
  end

  // Applies one item to the slot model and returns the result it should produce.
  // The generation-wrap exhaust path needs 2^64 reserves of one slot, so it is
  // modelled but never reached.
  function automatic grant_result_t track_slot_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                                  logic [GEN_W-1:0] gen, logic [ID_W-1:0] plan,
                                                  logic [ID_W-1:0] ord);
    grant_result_t r;
    slot_state_t   want;
    bit            hit;
    r = '0;
    r.status = RC_OK;
    hit = 1'b0;
    case (op)
      OP_RESERVE: begin
        if (is_poisoned || plan == '0 || ord == '0) begin
          r.status = RC_PRECOND;
        end else begin
          for (int k = 0; k < SLOTS; k++)
            if (lane_state[k] != ST_FREE && lane_plan[k] == plan && lane_ord[k] == ord) hit = 1'b1;
          if (hit) begin
            r.status = RC_PRECOND;
          end else begin
            r.status = RC_EXHAUSTED;
            for (int k = 0; k < SLOTS; k++) begin
              if (!hit && lane_state[k] == ST_FREE) begin
                hit = 1'b1;
                if (&lane_gen[k]) begin
                  is_poisoned = 1'b1;
                end else begin
                  lane_gen[k]   = lane_gen[k] + 1'b1;
                  lane_plan[k]  = plan;
                  lane_ord[k]   = ord;
                  lane_state[k] = ST_PREPARED;
                  r.status      = RC_OK;
                  r.index       = IDX_W'(k);
                  r.generation  = lane_gen[k];
                end
              end
            end
          end
        end
      end
      OP_ABORT, OP_COMMIT, OP_COMPLETE, OP_RELEASE, OP_SUSPECT: begin
        if (op == OP_ABORT || op == OP_COMMIT) want = ST_PREPARED;
        else if (op == OP_RELEASE)             want = ST_VERIFIED;
        else                                   want = ST_COMMITTED;
        if (idx >= SLOTS || gen == '0 || plan == '0 || ord == '0) begin
          r.status = RC_INVALID;
        end else if (lane_state[idx] != want || lane_gen[idx] != gen ||
                     lane_plan[idx] != plan || lane_ord[idx] != ord) begin
          r.status = RC_PRECOND;
        end else begin
          case (op)
            OP_ABORT, OP_RELEASE: begin
              lane_state[idx] = ST_FREE;
              lane_plan[idx]  = '0;
              lane_ord[idx]   = '0;
            end
            OP_COMMIT:   lane_state[idx] = ST_COMMITTED;
            OP_COMPLETE: lane_state[idx] = ST_VERIFIED;
            default: begin
              lane_state[idx] = ST_SUSPECT;
              is_poisoned     = 1'b1;
            end
          endcase
        end
      end
      default: r.status = RC_INVALID;
    endcase
    r.poisoned = is_poisoned;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    logic [ID_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) v = '1;
    if (v == '0) v = ID_W'(1);
    return v;
  endfunction

  // Legal next step for a live slot; never a suspect unless allowed
  function automatic op_t next_step_op(int k, bit allow_suspect);
    op_t op;
    op = OP_COMMIT;
    if (lane_state[k] == ST_PREPARED) begin
      if ($urandom_range(0, 3) == 0) op = OP_ABORT;
    end else if (lane_state[k] == ST_COMMITTED) begin
      op = OP_COMPLETE;
      if (allow_suspect && $urandom_range(0, 5) == 0) op = OP_SUSPECT;
    end else if (lane_state[k] == ST_VERIFIED) begin
      op = OP_RELEASE;
    end
    return op;
  endfunction

  // Drives one item, holds it until accepted, then idles the sender between bursts
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen,
                           logic [ID_W-1:0] plan, logic [ID_W-1:0] ord);
    int gap;
    in_valid             <= 1'b1;
    in_opcode            <= op;
    in_slot_index        <= idx;
    in_handle_generation <= gen;
    in_plan_sequence     <= plan;
    in_op_ordinal        <= ord;
    do @(posedge clk); while (in_stall);
    expected_grants.push_back(track_slot_op(op, idx, gen, plan, ord));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_handle(op_t op, int k);
    send_item(op, IDX_W'(k), lane_gen[k], lane_plan[k], lane_ord[k]);
  endtask

  // Malformed or out-of-order items, mostly built from a real handle
  task automatic send_noise(bit allow_suspect);
    int               k;
    int               b;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic [ID_W-1:0]  plan;
    logic [ID_W-1:0]  ord;
    k    = $urandom_range(0, SLOTS - 1);
    b    = $urandom_range(0, 63);
    op   = next_step_op(k, 1'b0);
    idx  = IDX_W'(k);
    gen  = lane_gen[k];
    plan = lane_plan[k];
    ord  = lane_ord[k];
    case ($urandom_range(0, 8))
      0: begin
        op   = OP_W'($urandom_range(0, 7));
        idx  = IDX_W'($urandom_range(0, 15));
        gen  = ($urandom_range(0, 1) == 0) ? GEN_W'($urandom_range(0, 3)) : {$urandom, $urandom};
        plan = {$urandom, $urandom};
        ord  = {$urandom, $urandom};
      end
      1: begin
        op = OP_W'($urandom_range(1, 5));
        if (op == OP_SUSPECT && !allow_suspect) op = OP_COMPLETE;
      end
      2: gen[b]  = ~gen[b];
      3: plan[b] = ~plan[b];
      4: ord[b]  = ~ord[b];
      5: begin
        case ($urandom_range(0, 2))
          0:       gen  = '0;
          1:       plan = '0;
          default: ord  = '0;
        endcase
      end
      6: if (SLOTS < 16) idx = IDX_W'($urandom_range(SLOTS, 15));
      7: op = OP_W'($urandom_range(6, 7));
      default: begin
        // reserve repeating a slot's ids, or with one id zero
        op = OP_RESERVE;
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 1) == 0) plan = '0;
          else ord = '0;
        end
      end
    endcase
    send_item(op, idx, gen, plan, ord);
  endtask

  task automatic run_lifecycle_mix(int count, bit allow_suspect);
    int live[$];
    int free_k;
    int pick;
    int k;
    for (int n = 0; n < count; n++) begin
      live.delete();
      free_k = -1;
      for (int s = 0; s < SLOTS; s++) begin
        if (lane_state[s] == ST_FREE) free_k = s;
        else if (lane_state[s] != ST_SUSPECT) live.push_back(s);
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_noise(allow_suspect);
      end else if ((free_k >= 0 && (live.size() == 0 || pick < 50)) || pick < 25) begin
        send_item(OP_RESERVE, IDX_W'($urandom_range(0, 15)), {$urandom, $urandom}, rand_id(),
                  rand_id());
      end else if (live.size() != 0) begin
        k = live[$urandom_range(0, live.size() - 1)];
        send_handle(next_step_op(k, allow_suspect), k);
      end else begin
        send_noise(allow_suspect);
      end
    end
  endtask

  task automatic test_reserve_edges();
    send_item(OP_RESERVE, '0, '0, ID_W'(1), ID_W'(1));
    send_item(OP_RESERVE, '1, '1, '1, '1);
    send_item(OP_RESERVE, '0, '0, '1, '1);     // duplicate of a held slot
    send_item(OP_RESERVE, '0, '0, ID_W'(5), ID_W'(6));       // no slot free
    send_item(OP_RESERVE, '0, '0, '0, ID_W'(7));
    send_item(OP_RESERVE, '0, '0, ID_W'(7), '0);
  endtask

  task automatic test_handle_checks();
    send_item(OP_COMMIT, IDX_W'(SLOTS), lane_gen[0], lane_plan[0], lane_ord[0]);
    send_item(OP_COMMIT, '1, lane_gen[0], lane_plan[0], lane_ord[0]);
    send_item(OP_COMMIT, '0, '0, lane_plan[0], lane_ord[0]);
    send_item(OP_COMMIT, '0, lane_gen[0], '0, lane_ord[0]);
    send_item(OP_COMMIT, '0, lane_gen[0], lane_plan[0], '0);
    send_item(OP_COMMIT, '0, lane_gen[0] + 1'b1, lane_plan[0], lane_ord[0]);
    send_handle(OP_COMPLETE, 0);               // wrong state for each of these
    send_handle(OP_RELEASE, 0);
    send_handle(OP_SUSPECT, 0);
    send_item(3'd6, '0, GEN_W'(1), ID_W'(1), ID_W'(1));
    send_item(3'd7, '1, '1, '1, '1);
  endtask

  task automatic test_full_lifecycle();
    send_handle(OP_COMMIT, 0);
    send_handle(OP_COMPLETE, 0);
    send_handle(OP_RELEASE, 0);
    send_handle(OP_ABORT, 1);
    send_item(OP_RESERVE, '0, '0, ID_W'(3), ID_W'(4));       // slot 0 comes back one generation on
  endtask

  task automatic test_poisoning();
    int k;
    int guard;
    guard = 0;
    k = -1;
    while (k < 0 && guard < 20) begin
      for (int s = 0; s < SLOTS; s++)
        if (lane_state[s] == ST_COMMITTED) k = s;
      if (k < 0) begin
        for (int s = 0; s < SLOTS; s++)
          if (lane_state[s] == ST_PREPARED) k = s;
        if (k >= 0) send_handle(OP_COMMIT, k);
        else send_item(OP_RESERVE, '0, '0, rand_id(), rand_id());
        k = -1;
      end
      guard++;
    end
    if (k >= 0) begin
      send_item(OP_SUSPECT, IDX_W'(k), lane_gen[k], lane_plan[k], lane_ord[k] ^ 64'h1);
      send_handle(OP_SUSPECT, k);
      send_item(OP_RESERVE, '0, '0, rand_id(), rand_id());
      send_handle(OP_COMMIT, k);
      send_handle(OP_RELEASE, k);
    end
  endtask

  // Receiver stall pattern: switches between free running, light, heavy and periodic
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((cycles % 8) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("** credit_slot_lifecycle_tracker: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    grant_result_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d", $time, out_status);
      end else begin
        exp = expected_grants.pop_front();
        if (out_status !== exp.status) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time, exp.status, out_status);
        end
        if (out_granted_index !== exp.index) begin
          errors++;
          $display("%0t: granted_index expected %0d, got %0d", $time, exp.index,
                   out_granted_index);
        end
        if (out_granted_generation !== exp.generation) begin
          errors++;
          $display("%0t: granted_generation expected %h, got %h", $time, exp.generation,
                   out_granted_generation);
        end
        if (out_poisoned_flag !== exp.poisoned) begin
          errors++;
          $display("%0t: poisoned_flag expected %0d, got %0d", $time, exp.poisoned,
                   out_poisoned_flag);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reserve_edges();
    test_handle_checks();
    test_full_lifecycle();
    run_lifecycle_mix(1700, 1'b0);
    test_poisoning();
    run_lifecycle_mix(220, 1'b1);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** credit_slot_lifecycle_tracker: PASSED **");
    end else begin
      $display("** credit_slot_lifecycle_tracker: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
